/* rtl/mrtq_pkg.sv */
// Package for the multi-ring task queue core.
// Holds parameter defaults, operation codes and sequencer state codes.
// Depends on nothing.
`default_nettype none

package mrtq_pkg;

    localparam int DEF_NUM_QUEUES = 4;
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_ID_BITS    = 8;

    localparam int OP_BITS     = 3;
    localparam int SEL_BITS    = 2;
    localparam int IDENT_BITS  = 8;
    localparam int COUNT_BITS  = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENQUEUE = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_PEEK    = 3'd2,
        OP_EXISTS  = 3'd3,
        OP_REMOVE  = 3'd4
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_RDWAIT = 6'b000100,
        S_SCAN   = 6'b001000,
        S_COPY   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

/* rtl/multi_ring_task_queue_core.sv */
// Top level of the multi-ring task queue core: ring queues, slot memory,
// survivor buffer and the sequencer that walks them.
// Depends on mrtq_pkg.
//
// A transaction is accepted at a rising edge with start high and busy low.
// busy stays high until the single result has been shown. The result is on
// the o_ ports for exactly one cycle, marked by o_valid, and cannot be held
// off by the receiver. How each operation runs once it has been accepted:
//   enqueue, invalid operation or queue: settled in the execute state.
//   dequeue, peek: one registered slot memory read.
//   exists: one stored entry read per cycle, stopping early at a match.
//   remove: a scan that writes the survivors into the survivor buffer, then
//   a copy of them back to slot 0 upward.
// The next transaction may start the cycle after o_valid. The slot memory port
// (one read or one write per cycle) sets the pace of the scan and the copy.
// Synchronous reset empties every queue; slot contents are left as they are.
`default_nettype none

module multi_ring_task_queue_core #(
    parameter int NUM_QUEUES = mrtq_pkg::DEF_NUM_QUEUES,
    parameter int DEPTH      = mrtq_pkg::DEF_DEPTH,
    parameter int ID_BITS    = mrtq_pkg::DEF_ID_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [mrtq_pkg::OP_BITS-1:0]     i_operation,
    input  wire logic [mrtq_pkg::SEL_BITS-1:0]    i_queue_select,
    input  wire logic [mrtq_pkg::IDENT_BITS-1:0]  i_task_ident,
    output logic                                  o_valid,
    output logic                                  o_ok,
    output logic [mrtq_pkg::IDENT_BITS-1:0]       o_task_out,
    output logic                                  o_queue_empty,
    output logic                                  o_queue_full,
    output logic [mrtq_pkg::COUNT_BITS-1:0]       o_entry_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW = $clog2(NUM_QUEUES * DEPTH);

    mrtq_pkg::t_state r_state, n_state;
    mrtq_pkg::t_op    r_op, n_op;
    logic [QW-1:0]      r_q, n_q;
    logic               r_qok, n_qok;
    logic [ID_BITS-1:0] r_id, n_id;
    logic               r_ok, n_ok;
    logic [ID_BITS-1:0] r_tout, n_tout;
    logic [PW-1:0]      r_i, n_i;
    logic [PW-1:0]      r_p, n_p;
    logic [PW-1:0]      r_n, n_n;
    logic               r_rdv, n_rdv;

    logic [PW-1:0] r_head [NUM_QUEUES];
    logic [PW-1:0] n_head [NUM_QUEUES];
    logic [PW-1:0] r_tail [NUM_QUEUES];
    logic [PW-1:0] n_tail [NUM_QUEUES];
    logic [PW-1:0] r_cnt  [NUM_QUEUES];
    logic [PW-1:0] n_cnt  [NUM_QUEUES];

    logic [ID_BITS-1:0] r_mem [NUM_QUEUES*DEPTH];
    logic [ID_BITS-1:0] r_mem_rd;
    logic [ID_BITS-1:0] r_keep [DEPTH];
    logic [ID_BITS-1:0] r_keep_rd;

    logic               mem_we, mem_re, keep_we, keep_re;
    logic [PW-1:0]      mem_wptr, mem_rptr;
    logic [ID_BITS-1:0] mem_wd;
    logic [AW-1:0]      mem_base;

    logic [PW-1:0] cur_head, cur_tail, cur_cnt;
    logic          cur_empty, cur_full;

    function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] res;
        if (p == PW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = PW'(p + 1'b1);
        end
        return res;
    endfunction

    assign cur_head  = r_head[r_q];
    assign cur_tail  = r_tail[r_q];
    assign cur_cnt   = r_cnt[r_q];
    assign cur_empty = (cur_head == cur_tail);
    assign cur_full  = (nxt_ptr(cur_tail) == cur_head);
    assign mem_base  = AW'(AW'(r_q) * AW'(DEPTH));

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_q      = r_q;
        n_qok    = r_qok;
        n_id     = r_id;
        n_ok     = r_ok;
        n_tout   = r_tout;
        n_i      = r_i;
        n_p      = r_p;
        n_n      = r_n;
        n_rdv    = r_rdv;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        keep_we  = 1'b0;
        keep_re  = 1'b0;
        mem_wptr = cur_tail;
        mem_rptr = cur_head;
        mem_wd   = r_id;

        case (r_state)
            mrtq_pkg::S_IDLE: begin
                if (start) begin
                    n_op    = mrtq_pkg::t_op'(i_operation);
                    n_qok   = (32'(i_queue_select) < 32'(NUM_QUEUES));
                    n_q     = n_qok ? QW'(i_queue_select) : '0;
                    n_id    = ID_BITS'(i_task_ident);
                    n_ok    = 1'b0;
                    n_tout  = '0;
                    n_state = mrtq_pkg::S_EXEC;
                end
            end
            mrtq_pkg::S_EXEC: begin
                n_state = mrtq_pkg::S_DONE;
                if (r_qok) begin
                    case (r_op)
                        mrtq_pkg::OP_ENQUEUE: begin
                            if (!cur_full) begin
                                mem_we      = 1'b1;
                                n_tail[r_q] = nxt_ptr(cur_tail);
                                n_cnt[r_q]  = PW'(cur_cnt + 1'b1);
                                n_ok        = 1'b1;
                            end
                        end
                        mrtq_pkg::OP_DEQUEUE, mrtq_pkg::OP_PEEK: begin
                            if (!cur_empty) begin
                                mem_re  = 1'b1;
                                n_state = mrtq_pkg::S_RDWAIT;
                            end
                        end
                        mrtq_pkg::OP_EXISTS, mrtq_pkg::OP_REMOVE: begin
                            if (!cur_empty) begin
                                n_i     = '0;
                                n_p     = cur_head;
                                n_n     = '0;
                                n_rdv   = 1'b0;
                                n_state = mrtq_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            n_state = mrtq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            mrtq_pkg::S_RDWAIT: begin
                n_tout = r_mem_rd;
                n_ok   = 1'b1;
                if (r_op == mrtq_pkg::OP_DEQUEUE) begin
                    n_head[r_q] = nxt_ptr(cur_head);
                    n_cnt[r_q]  = PW'(cur_cnt - 1'b1);
                end
                n_state = mrtq_pkg::S_DONE;
            end
            mrtq_pkg::S_SCAN: begin
                mem_rptr = r_p;
                n_rdv    = (r_i != cur_cnt);
                if (r_i != cur_cnt) begin
                    mem_re = 1'b1;
                    n_p    = nxt_ptr(r_p);
                    n_i    = PW'(r_i + 1'b1);
                end
                if (r_rdv) begin
                    if (r_op == mrtq_pkg::OP_EXISTS) begin
                        if (r_mem_rd == r_id) begin
                            n_ok    = 1'b1;
                            n_state = mrtq_pkg::S_DONE;
                        end
                    end else if (r_mem_rd != r_id) begin
                        keep_we = 1'b1;
                        n_n     = PW'(r_n + 1'b1);
                    end
                end else if (r_i == cur_cnt) begin
                    if (r_op == mrtq_pkg::OP_EXISTS) begin
                        n_state = mrtq_pkg::S_DONE;
                    end else if (r_n == '0) begin
                        n_head[r_q] = '0;
                        n_tail[r_q] = '0;
                        n_cnt[r_q]  = '0;
                        n_ok        = 1'b1;
                        n_state     = mrtq_pkg::S_DONE;
                    end else begin
                        n_i     = '0;
                        n_p     = '0;
                        n_rdv   = 1'b0;
                        n_state = mrtq_pkg::S_COPY;
                    end
                end
            end
            mrtq_pkg::S_COPY: begin
                mem_wptr = r_p;
                mem_wd   = r_keep_rd;
                n_rdv    = (r_i != r_n);
                if (r_i != r_n) begin
                    keep_re = 1'b1;
                    n_i     = PW'(r_i + 1'b1);
                end
                if (r_rdv) begin
                    mem_we = 1'b1;
                    n_p    = PW'(r_p + 1'b1);
                end else if (r_i == r_n) begin
                    n_head[r_q] = '0;
                    n_tail[r_q] = r_n;
                    n_cnt[r_q]  = r_n;
                    n_ok        = 1'b1;
                    n_state     = mrtq_pkg::S_DONE;
                end
            end
            mrtq_pkg::S_DONE: begin
                n_state = mrtq_pkg::S_IDLE;
            end
            default: begin
                n_state = mrtq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrtq_pkg::S_IDLE;
            r_rdv   <= 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rdv   <= n_rdv;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_q    <= n_q;
        r_qok  <= n_qok;
        r_id   <= n_id;
        r_ok   <= n_ok;
        r_tout <= n_tout;
        r_i    <= n_i;
        r_p    <= n_p;
        r_n    <= n_n;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_base + AW'(mem_wptr)] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_rd <= r_mem[mem_base + AW'(mem_rptr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep_we) begin
            r_keep[r_n] <= r_mem_rd;
        end
        if (keep_re) begin
            r_keep_rd <= r_keep[r_i];
        end
    end

    assign busy          = (r_state != mrtq_pkg::S_IDLE);
    assign o_valid       = (r_state == mrtq_pkg::S_DONE);
    assign o_ok          = r_ok;
    assign o_task_out    = mrtq_pkg::IDENT_BITS'(r_tout);
    assign o_queue_empty = r_qok & cur_empty;
    assign o_queue_full  = r_qok & cur_full;
    assign o_entry_count = r_qok ? mrtq_pkg::COUNT_BITS'(cur_cnt) : '0;

`ifndef ASSERT_OFF
    a_valid_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe lasted more than one cycle.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_queue_empty && o_queue_full))
        else $error("Queue reported both empty and full.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_queue_empty) |-> (r_cnt[r_q] == '0))
        else $error("Empty queue has a nonzero entry count.");

    a_copy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrtq_pkg::S_COPY) |-> (r_n != '0))
        else $error("Copy pass started with no survivors.");
`endif

endmodule

`default_nettype wire
